// File: hw/rtl/two_class_priority_wait_queue_top_defines.svh
// Assertion macros used by the wait queue datapath.
// Depends on nothing; files that check their logic include it.
`ifndef TWO_CLASS_PRIORITY_WAIT_QUEUE_TOP_DEFINES_SVH
`define TWO_CLASS_PRIORITY_WAIT_QUEUE_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TCPWQ_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TCPWQ_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tcpwq_pkg.sv
// Shared types and constants of the two-class wait queue.
// Used by the controller, the datapath and the top level.
package tcpwq_pkg;

    localparam int U_DEPTH = 16;
    localparam int H_DEPTH = 16;
    localparam int U_AW    = $clog2(U_DEPTH);
    localparam int H_AW    = $clog2(H_DEPTH);
    localparam int U_CW    = $clog2(U_DEPTH + 1);
    localparam int H_CW    = $clog2(H_DEPTH + 1);
    localparam int TAG_W   = 8;
    localparam int YEAR_W  = 12;
    localparam int ENT_W   = YEAR_W + TAG_W;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_POSM1,
        RS_IDX
    } t_rsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_U_POP,
        S_INS_RD,
        S_INS_CMP,
        S_H_TOP,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    u_rd;
        logic    u_push;
        logic    u_pop;
        logic    h_rd;
        t_rsel   h_rsel;
        logic    h_wr_new;
        logic    h_wr_shift;
        logic    h_wr_move;
        logic    h_top;
        logic    h_dec;
        logic    res_set;
        t_status res_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic urgent;
        logic u_full;
        logic u_empty;
        logic h_full;
        logic h_empty;
        logic pos_zero;
        logic rd_greater;
        logic idx_end;
    } t_stat;

endpackage

// File: hw/rtl/two_class_priority_wait_queue_top.sv
// Top level of the two-class wait queue: controller plus datapath.
// Depends on tcpwq_pkg, tcpwq_ctrl and tcpwq_dpath.
//
// Usage: raise start with a word on i_mode, i_is_urgent, i_entry_tag and
// i_entry_year; it is taken at a clock edge where busy is low. Mode 0
// enqueues (urgent entries into a FIFO, regular ones into a list sorted by
// year, equal years kept in arrival order); mode 1 serves the urgent FIFO
// first, otherwise the regular entry with the smallest year.
// Every word gives exactly one result, shown for one cycle with o_done
// high on o_status, o_served_tag, o_served_urgent and o_waiting_count.
// An urgent enqueue, a refusal or an empty dequeue goes from dispatch straight
// to the response; an urgent dequeue reads the FIFO, then pops it. A regular
// insertion walks the list from the back, moving each entry of larger year up
// one place before writing the new entry; a regular dequeue reads the front,
// then moves every remaining entry down one place. The regular list walk does
// one memory read and one write per entry moved. busy stays high through the
// o_done cycle, so the next word is taken only after busy falls again.
// Reset (synchronous, active low) empties both classes. The receiver
// cannot stall: each result is valid only in its o_done cycle.
module two_class_priority_wait_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic                          i_is_urgent,
    input  logic [tcpwq_pkg::TAG_W-1:0]   i_entry_tag,
    input  logic [tcpwq_pkg::YEAR_W-1:0]  i_entry_year,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [tcpwq_pkg::TAG_W-1:0]   o_served_tag,
    output logic                          o_served_urgent,
    output logic [5:0]                    o_waiting_count
);
    import tcpwq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    tcpwq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Stores and result registers.
    tcpwq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_is_urgent     (i_is_urgent),
        .i_entry_tag     (i_entry_tag),
        .i_entry_year    (i_entry_year),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_served_tag    (o_served_tag),
        .o_served_urgent (o_served_urgent),
        .o_waiting_count (o_waiting_count)
    );

endmodule

// File: hw/rtl/tcpwq_dpath.sv
// Datapath of the wait queue: urgent FIFO memory, sorted regular memory,
// pointers, fill counts and result registers. Depends on tcpwq_pkg.
`include "two_class_priority_wait_queue_top_defines.svh"
module tcpwq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_mode,
    input  logic                          i_is_urgent,
    input  logic [tcpwq_pkg::TAG_W-1:0]   i_entry_tag,
    input  logic [tcpwq_pkg::YEAR_W-1:0]  i_entry_year,
    input  tcpwq_pkg::t_cmd               i_cmd,
    output tcpwq_pkg::t_stat              o_stat,
    output logic [1:0]                    o_status,
    output logic [tcpwq_pkg::TAG_W-1:0]   o_served_tag,
    output logic                          o_served_urgent,
    output logic [5:0]                    o_waiting_count
);
    import tcpwq_pkg::*;

    logic                r_mode;
    logic                r_urg;
    logic [TAG_W-1:0]    r_tag;
    logic [YEAR_W-1:0]   r_year;
    logic [TAG_W-1:0]    r_u_mem [U_DEPTH];
    logic [U_AW-1:0]     r_u_head;
    logic [U_AW-1:0]     r_u_tail;
    logic [U_CW-1:0]     r_u_fill;
    logic [TAG_W-1:0]    r_u_rd;
    logic [ENT_W-1:0]    r_h_mem [H_DEPTH];
    logic [H_CW-1:0]     r_h_fill;
    logic [H_CW-1:0]     r_pos;
    logic [H_CW-1:0]     r_idx;
    logic [ENT_W-1:0]    r_h_rd;
    t_status             r_res_status;
    logic [TAG_W-1:0]    r_res_tag;
    logic                r_res_urg;
    logic [H_AW-1:0]     h_raddr;
    logic [H_AW-1:0]     h_waddr;
    logic [ENT_W-1:0]    h_wdata;
    logic                h_we;
    logic [H_CW-1:0]     pos_m1;
    logic [H_CW-1:0]     idx_m1;

    assign pos_m1 = r_pos - H_CW'(1);
    assign idx_m1 = r_idx - H_CW'(1);

    // Status towards the controller.
    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.urgent     = r_urg;
        o_stat.u_full     = (r_u_fill == U_CW'(U_DEPTH));
        o_stat.u_empty    = (r_u_fill == '0);
        o_stat.h_full     = (r_h_fill == H_CW'(H_DEPTH));
        o_stat.h_empty    = (r_h_fill == '0);
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.rd_greater = (r_h_rd[ENT_W-1:TAG_W] > r_year);
        o_stat.idx_end    = (r_idx >= r_h_fill);
    end

    // Regular memory read address, write address and write data.
    always_comb begin
        case (i_cmd.h_rsel)
            RS_ZERO:  h_raddr = '0;
            RS_POSM1: h_raddr = pos_m1[H_AW-1:0];
            RS_IDX:   h_raddr = r_idx[H_AW-1:0];
            default:  h_raddr = '0;
        endcase
        h_we    = i_cmd.h_wr_new | i_cmd.h_wr_shift | i_cmd.h_wr_move;
        h_waddr = i_cmd.h_wr_move ? idx_m1[H_AW-1:0] : r_pos[H_AW-1:0];
        h_wdata = i_cmd.h_wr_new ? {r_year, r_tag} : r_h_rd;
    end

    // Urgent FIFO memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.u_push) begin
            r_u_mem[r_u_tail] <= r_tag;
        end
        if (i_cmd.u_rd) begin
            r_u_rd <= r_u_mem[r_u_head];
        end
    end

    // Regular memory, kept sorted by year with stable insertion.
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_h_mem[h_waddr] <= h_wdata;
        end
        if (i_cmd.h_rd) begin
            r_h_rd <= r_h_mem[h_raddr];
        end
    end

    // Latched item word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_urg  <= i_is_urgent;
            r_tag  <= i_entry_tag;
            r_year <= i_entry_year;
        end
    end

    // Pointers, counts and walk indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_head <= '0;
            r_u_tail <= '0;
            r_u_fill <= '0;
            r_h_fill <= '0;
            r_pos    <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= r_h_fill;
                r_idx <= H_CW'(1);
            end
            if (i_cmd.u_push) begin
                r_u_tail <= (r_u_tail == U_AW'(U_DEPTH - 1)) ? '0 : r_u_tail + U_AW'(1);
                r_u_fill <= r_u_fill + U_CW'(1);
            end
            if (i_cmd.u_pop) begin
                r_u_head <= (r_u_head == U_AW'(U_DEPTH - 1)) ? '0 : r_u_head + U_AW'(1);
                r_u_fill <= r_u_fill - U_CW'(1);
            end
            if (i_cmd.h_wr_new) begin
                r_h_fill <= r_h_fill + H_CW'(1);
            end
            if (i_cmd.h_dec) begin
                r_h_fill <= r_h_fill - H_CW'(1);
            end
            if (i_cmd.h_wr_shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.h_wr_move) begin
                r_idx <= r_idx + H_CW'(1);
            end
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_status <= ST_OK;
            r_res_tag    <= '0;
            r_res_urg    <= 1'b0;
        end else begin
            if (i_cmd.res_set) begin
                r_res_status <= i_cmd.res_code;
            end
            if (i_cmd.u_pop) begin
                r_res_tag <= r_u_rd;
                r_res_urg <= 1'b1;
            end
            if (i_cmd.h_top) begin
                r_res_tag <= r_h_rd[TAG_W-1:0];
            end
        end
    end

    assign o_status        = r_res_status;
    assign o_served_tag    = r_res_tag;
    assign o_served_urgent = r_res_urg;
    assign o_waiting_count = 6'(r_u_fill) + 6'(r_h_fill);

    `TCPWQ_HOLDS(a_u_fill_range, 1'b1, r_u_fill <= U_CW'(U_DEPTH), "urgent fill overflow")
    `TCPWQ_HOLDS(a_h_fill_range, 1'b1, r_h_fill <= H_CW'(H_DEPTH), "regular fill overflow")
    `TCPWQ_NEXT(a_push_count, i_cmd.u_push, r_u_fill == U_CW'($past(r_u_fill) + U_CW'(1)), "urgent push lost")

endmodule

// File: hw/rtl/tcpwq_ctrl.sv
// Controller state machine of the wait queue.
// Depends on tcpwq_pkg; drives the datapath by command words.
module tcpwq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    input  tcpwq_pkg::t_stat i_stat,
    output tcpwq_pkg::t_cmd  o_cmd
);
    import tcpwq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_stat.mode) begin
                    if (i_stat.urgent) begin
                        if (i_stat.u_full) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_code = ST_FULL;
                        end else begin
                            o_cmd.u_push = 1'b1;
                        end
                        n_state = S_RESP;
                    end else if (i_stat.h_full) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_FULL;
                        n_state        = S_RESP;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else if (!i_stat.u_empty) begin
                    o_cmd.u_rd = 1'b1;
                    n_state    = S_U_POP;
                end else if (!i_stat.h_empty) begin
                    o_cmd.h_rd   = 1'b1;
                    o_cmd.h_rsel = RS_ZERO;
                    n_state      = S_H_TOP;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                    n_state        = S_RESP;
                end
            end
            S_U_POP: begin
                o_cmd.u_pop = 1'b1;
                n_state     = S_RESP;
            end
            S_INS_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.h_wr_new = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.h_rd   = 1'b1;
                    o_cmd.h_rsel = RS_POSM1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.rd_greater) begin
                    o_cmd.h_wr_shift = 1'b1;
                    n_state          = S_INS_RD;
                end else begin
                    o_cmd.h_wr_new = 1'b1;
                    n_state        = S_RESP;
                end
            end
            S_H_TOP: begin
                o_cmd.h_top = 1'b1;
                n_state     = S_SH_RD;
            end
            S_SH_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.h_dec = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.h_rd   = 1'b1;
                    o_cmd.h_rsel = RS_IDX;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.h_wr_move = 1'b1;
                n_state         = S_SH_RD;
            end
            S_RESP: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the two-class wait queue top level.
// Depends on tcpwq_pkg and two_class_priority_wait_queue_top; a small class
// keeps the predicted queue state and checks each result word against it.
`timescale 1ns / 100ps

class wait_queue_scoreboard;
    // Predicted state: urgent FIFO and regular list kept in service order.
    logic [7:0]  urgent_tags[$];
    logic [19:0] regular_list[$];
    // Expected result words, oldest first.
    logic [16:0] pending_results[$];
    int          mismatches;

    function void report(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endfunction

    // Work out the result of an accepted word and update the state.
    function void note_word(logic mode, logic urgent, logic [7:0] tag, logic [11:0] year);
        tcpwq_pkg::t_status st;
        logic [7:0]         served;
        logic               served_u;
        logic [19:0]        head;
        int                 pos;
        st = tcpwq_pkg::ST_OK;
        served = '0;
        served_u = 1'b0;
        if (mode == 1'b0) begin
            if (urgent) begin
                if (urgent_tags.size() >= tcpwq_pkg::U_DEPTH) st = tcpwq_pkg::ST_FULL;
                else urgent_tags.push_back(tag);
            end else begin
                if (regular_list.size() >= tcpwq_pkg::H_DEPTH) begin
                    st = tcpwq_pkg::ST_FULL;
                end else begin
                    // Stable insertion after every entry of equal or smaller year.
                    pos = regular_list.size();
                    while (pos > 0 && regular_list[pos-1][19:8] > year) pos--;
                    regular_list.insert(pos, {year, tag});
                end
            end
        end else if (urgent_tags.size() > 0) begin
            served = urgent_tags.pop_front();
            served_u = 1'b1;
        end else if (regular_list.size() > 0) begin
            head = regular_list.pop_front();
            served = head[7:0];
        end else begin
            st = tcpwq_pkg::ST_EMPTY;
        end
        pending_results.push_back({st, served, served_u,
                                   6'(urgent_tags.size() + regular_list.size())});
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [1:0] st, logic [7:0] tag, logic u, logic [5:0] cnt);
        logic [16:0] exp_word;
        if (pending_results.size() == 0) begin
            report("result with nothing expected");
            return;
        end
        exp_word = pending_results.pop_front();
        if (st !== exp_word[16:15]) report("status differs");
        if (tag !== exp_word[14:7]) report("served tag differs");
        if (u !== exp_word[6]) report("served class differs");
        if (cnt !== exp_word[5:0]) report("waiting count differs");
    endfunction
endclass

module testbench;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_mode = 1'b0;
    logic       i_is_urgent = 1'b0;
    logic [7:0] i_entry_tag = '0;
    logic [11:0] i_entry_year = '0;
    logic       o_done;
    logic [1:0] o_status;
    logic [7:0] o_served_tag;
    logic       o_served_urgent;
    logic [5:0] o_waiting_count;
    int         cycle_count = 0;

    wait_queue_scoreboard queue_model = new();

    two_class_priority_wait_queue_top DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result monitor and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done)
            queue_model.check_result(o_status, o_served_tag, o_served_urgent, o_waiting_count);
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one word, wait for acceptance, then an optional gap.
    task automatic send_word(logic mode, logic urgent, logic [7:0] tag, logic [11:0] year,
                             int gap);
        start <= 1'b1;
        i_mode <= mode;
        i_is_urgent <= urgent;
        i_entry_tag <= tag;
        i_entry_year <= year;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queue_model.note_word(mode, urgent, tag, year);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int enq_weight, int burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        send_word(($urandom_range(0, 99) >= enq_weight), 1'($urandom_range(0, 1)),
                  8'($urandom), ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                 : 12'($urandom_range(2000, 2007)), gap);
    endtask

    task automatic drain_wait();
        start <= 1'b0;
        @(posedge i_clk);
        while (queue_model.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int i;
        int weight;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, extremes, equal years, both classes full.
        send_word(1'b1, 1'b0, 8'h00, 12'h000, 0);
        send_word(1'b0, 1'b0, 8'hFF, 12'hFFF, 1);
        send_word(1'b0, 1'b0, 8'h00, 12'h000, 0);
        send_word(1'b0, 1'b0, 8'hA5, 12'h7D0, 0);
        send_word(1'b0, 1'b0, 8'h5A, 12'h7D0, 2);
        send_word(1'b0, 1'b1, 8'hFF, 12'hFFF, 0);
        for (i = 0; i < 6; i++) send_word(1'b1, 1'b0, 8'h00, 12'h000, 0);
        for (i = 0; i < 17; i++) send_word(1'b0, 1'b1, 8'(i), 12'h000, 0);
        drain_wait();
        for (i = 0; i < 17; i++) send_word(1'b0, 1'b0, 8'(i + 8'h80), 12'(i % 3), 0);
        drain_wait();

        // Random phases: fill-biased, balanced and drain-biased mixes.
        for (i = 0; i < 1400; i++) begin
            weight = ((i / 100) % 3 == 0) ? 75 : ((i / 100) % 3 == 1) ? 50 : 25;
            send_random(weight, ((i / 50) % 4) == 0);
            if (i == 700) drain_wait();
        end

        drain_wait();
        repeat (40) @(posedge i_clk);
        if (queue_model.pending_results.size() == 0 && queue_model.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: two_class_priority_wait_queue_top.f
+incdir+hw/rtl
hw/rtl/tcpwq_pkg.sv
hw/rtl/tcpwq_dpath.sv
hw/rtl/tcpwq_ctrl.sv
hw/rtl/two_class_priority_wait_queue_top.sv
sim/testbench.sv
